// ===== hdl/windowed_bandwidth_average_defines.svh =====
// Assertion macros shared by the windowed bandwidth average RTL.
// Included by the modules that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef WINDOWED_BANDWIDTH_AVERAGE_DEFINES_SVH
`define WINDOWED_BANDWIDTH_AVERAGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define WBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define WBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/wba_pkg.sv =====
// Package for the windowed bandwidth average: widths, reset values and the
// control structs passed between the ring memory, the divider and the top level.
`timescale 1ns / 1ps

package wba_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned WL_W     = 5;

  // Default ring depth and reset window length.
  localparam int unsigned WINDOW_MAX_DEF = 16;
  localparam logic [WL_W-1:0] WINDOW_RESET = 5'd8;

  // Commands to the sample ring.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } ring_cmd_t;

  // Status from the serial divider.
  typedef struct packed {
    logic busy;
  } div_sts_t;

endpackage

// ===== hdl/wba_ring.sv =====
// Sample ring of the windowed bandwidth average: a synchronous memory with a
// registered read port and a valid bit per entry. Depends on wba_pkg.
`timescale 1ns / 1ps

module wba_ring #(
  parameter int unsigned DEPTH  = wba_pkg::WINDOW_MAX_DEF,
  parameter int unsigned SLOT_W = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  wba_pkg::ring_cmd_t           cmd,
  input  logic [SLOT_W-1:0]            addr,
  input  logic [wba_pkg::SAMPLE_W-1:0] wr_data,
  output logic [wba_pkg::SAMPLE_W-1:0] rd_data
);

  logic [wba_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]             valid_r;
  logic [wba_pkg::SAMPLE_W-1:0] rd_data_r;
  logic                         rd_valid_r;

  // Memory array: write port and registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  // Entry valid bits; an entry never written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        valid_r <= '0;
      end else if (cmd.wr_en) begin
        valid_r[addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_valid_r <= valid_r[addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

// ===== hdl/wba_div.sv =====
// Bit-serial restoring divider for the windowed bandwidth average: one
// quotient bit per cycle. Depends on wba_pkg for the status struct.
`timescale 1ns / 1ps

module wba_div #(
  parameter int unsigned SUM_W = 36,
  parameter int unsigned LEN_W = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [SUM_W-1:0]             dividend,
  input  logic [LEN_W-1:0]             divisor,
  output wba_pkg::div_sts_t            sts,
  output logic [wba_pkg::SAMPLE_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(SUM_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0] quo_r;
  logic [LEN_W-1:0] rem_r;
  logic [LEN_W-1:0] dsr_r;
  logic [LEN_W:0]   trial;
  logic [LEN_W:0]   diff;
  logic             fits;

  // Trial subtraction of the divisor from the shifted partial remainder.
  always_comb begin
    trial = {rem_r, quo_r[SUM_W-1]};
    diff  = trial - {1'b0, dsr_r};
    fits  = (trial >= {1'b0, dsr_r});
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(SUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Datapath: dividend shifts out at the top as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
      quo_r <= {quo_r[SUM_W-2:0], fits};
    end
  end

  assign sts.busy = busy_r;
  assign quotient = quo_r[wba_pkg::SAMPLE_W-1:0];

endmodule

// ===== hdl/windowed_bandwidth_average.sv =====
// Windowed bandwidth average: a moving average of 32-bit bandwidth samples
// over the newest window_length samples. Takes wba_pkg, wba_ring and wba_div.
`timescale 1ns / 1ps

// Each accepted sample replaces the oldest entry of a ring held in a
// synchronous memory, and the block returns the running sum divided by the
// window length, truncated; slots not yet written since reset or the last
// window_length write count as zero. A window_length of 0 acts as 1, and a
// value above WINDOW_MAX acts as WINDOW_MAX. One request is in flight at a
// time; the quotient comes from a bit-serial divider over SUM_W bits,
// where SUM_W = 32 + log2(WINDOW_MAX), which produces one quotient bit per
// cycle. The next request can be accepted in the cycle in which the result
// appears. The output register lets the next request be accepted while a
// result still waits. A write to window_length clears the ring at once
// through per-entry valid bits, so no clearing pass follows reset.

`include "windowed_bandwidth_average_defines.svh"

module windowed_bandwidth_average #(
  parameter int unsigned WINDOW_MAX = wba_pkg::WINDOW_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [wba_pkg::SAMPLE_W-1:0] in_sample,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [wba_pkg::SAMPLE_W-1:0] out_average,
  input  logic                         cfg_we,
  input  logic [wba_pkg::WL_W-1:0]     cfg_wdata
);

  localparam int unsigned SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned LEN_W  = $clog2(WINDOW_MAX + 1);
  localparam int unsigned EXT_W  = (LEN_W > wba_pkg::WL_W) ? LEN_W : wba_pkg::WL_W;
  localparam int unsigned SUM_W  = wba_pkg::SAMPLE_W + $clog2(WINDOW_MAX);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_DIV
  } state_t;

  state_t                       state_r, state_nxt;
  logic [wba_pkg::WL_W-1:0]     wl_r, wl_nxt;
  logic [SUM_W-1:0]             sum_r, sum_nxt;
  logic [SLOT_W-1:0]            slot_r, slot_nxt;
  logic [wba_pkg::SAMPLE_W-1:0] sample_r, sample_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [wba_pkg::SAMPLE_W-1:0] out_average_r, out_average_nxt;

  logic [EXT_W-1:0]             wl_ext;
  logic [LEN_W-1:0]             len;
  logic [SLOT_W-1:0]            cur_slot;
  logic [LEN_W-1:0]             slot_inc;
  logic                         in_take;
  logic                         out_free;
  wba_pkg::ring_cmd_t           ring_cmd;
  logic [SLOT_W-1:0]            ring_addr;
  logic [wba_pkg::SAMPLE_W-1:0] old_sample;
  logic                         div_start;
  wba_pkg::div_sts_t            div_sts;
  logic [wba_pkg::SAMPLE_W-1:0] div_quo;

  // Effective window length: zero acts as one, saturated at the ring depth.
  always_comb begin
    wl_ext = EXT_W'(wl_r);
    if (wl_ext == '0) begin
      len = LEN_W'(1);
    end else if (wl_ext > EXT_W'(WINDOW_MAX)) begin
      len = LEN_W'(WINDOW_MAX);
    end else begin
      len = wl_ext[LEN_W-1:0];
    end
  end

  // Slot written by the current request and the slot after it.
  always_comb begin
    cur_slot = (LEN_W'(slot_r) >= len) ? '0 : slot_r;
    slot_inc = LEN_W'(cur_slot) + LEN_W'(1);
  end

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Sequencer: read old entry, update sum and ring, then divide.
  always_comb begin
    state_nxt       = state_r;
    wl_nxt          = wl_r;
    sum_nxt         = sum_r;
    slot_nxt        = slot_r;
    sample_nxt      = sample_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_average_nxt = out_average_r;
    ring_cmd        = '0;
    ring_addr       = cur_slot;
    div_start       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          ring_cmd.rd_en = 1'b1;
          sample_nxt     = in_sample;
          state_nxt      = S_UPD;
        end
      end
      S_UPD: begin
        sum_nxt        = sum_r - SUM_W'(old_sample) + SUM_W'(sample_r);
        ring_cmd.wr_en = 1'b1;
        slot_nxt       = (slot_inc >= len) ? '0 : slot_inc[SLOT_W-1:0];
        div_start      = 1'b1;
        state_nxt      = S_DIV;
      end
      S_DIV: begin
        if (!div_sts.busy && out_free) begin
          out_valid_nxt   = 1'b1;
          out_average_nxt = div_quo;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A window length write clears the ring, the sum and the write slot.
    if (cfg_we) begin
      wl_nxt         = cfg_wdata;
      sum_nxt        = '0;
      slot_nxt       = '0;
      ring_cmd.clear = 1'b1;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      wl_r          <= wba_pkg::WINDOW_RESET;
      sum_r         <= '0;
      slot_r        <= '0;
      sample_r      <= '0;
      out_valid_r   <= 1'b0;
      out_average_r <= '0;
    end else begin
      state_r       <= state_nxt;
      wl_r          <= wl_nxt;
      sum_r         <= sum_nxt;
      slot_r        <= slot_nxt;
      sample_r      <= sample_nxt;
      out_valid_r   <= out_valid_nxt;
      out_average_r <= out_average_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

  // Sample ring and serial divider.
  wba_ring #(
    .DEPTH  (WINDOW_MAX),
    .SLOT_W (SLOT_W)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (ring_cmd),
    .addr    (ring_addr),
    .wr_data (sample_r),
    .rd_data (old_sample)
  );

  wba_div #(
    .SUM_W (SUM_W),
    .LEN_W (LEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (len),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  // The write slot always lies inside the effective window.
  `WBA_ASSERT_NOW(a_slot_in_window, 1'b1, LEN_W'(slot_r) < len, "write slot outside window")
  // An accepted request moves straight to the update step.
  `WBA_ASSERT_NEXT(a_take_to_upd, in_take, state_r == S_UPD, "accepted request not updated")
  // The divider is idle whenever a new division is started.
  `WBA_ASSERT_NOW(a_div_free, state_r == S_UPD, !div_sts.busy, "divider started while busy")
  // The divider is running in the cycle after the update step.
  `WBA_ASSERT_NEXT(a_div_runs, state_r == S_UPD, div_sts.busy, "divider did not start")
  // Finishing a division always presents a result.
  `WBA_ASSERT_NEXT(a_result_out, (state_r == S_DIV) && !div_sts.busy && out_free,
                   out_valid_r && (state_r == S_IDLE), "division finished without a result")

endmodule

// ===== verif/windowed_bandwidth_average_test.sv =====
// Self-checking testbench for windowed_bandwidth_average: random and directed
// bandwidth samples, window length changes, and idling on both sides.
// Depends on wba_pkg and the windowed_bandwidth_average RTL only.
`timescale 1ns / 1ps

module windowed_bandwidth_average_test;

  localparam int unsigned SW = wba_pkg::SAMPLE_W;
  localparam int unsigned LW = wba_pkg::WL_W;
  localparam int unsigned RING_DEPTH = wba_pkg::WINDOW_MAX_DEF;
  localparam int unsigned PHASES = 12;
  localparam int unsigned PHASE_REQUESTS = 112;
  localparam int unsigned SETTLE_CYCLES = 50;

  // Tracks the moving average the block should produce and the averages still owed.
  class AverageScoreboard;
    bit [SW-1:0] ring [RING_DEPTH];
    bit [35:0]   window_sum;
    bit [3:0]    next_slot;
    bit [LW-1:0] length_reg = wba_pkg::WINDOW_RESET;
    bit [SW-1:0] owed_averages [$];
    int unsigned failures;

    // A write to the length register empties the window, whatever the value.
    function void set_window(bit [LW-1:0] value);
      length_reg = value;
      foreach (ring[i]) ring[i] = '0;
      window_sum = '0;
      next_slot = '0;
    endfunction

    // An accepted request replaces the oldest sample and owes one average.
    function void note_sample(bit [SW-1:0] sample);
      int unsigned len;
      int unsigned pos;
      len = length_reg;
      if (len == 0) len = 1;
      if (len > RING_DEPTH) len = RING_DEPTH;
      pos = next_slot;
      if (pos >= len) pos = 0;
      window_sum = window_sum - ring[pos] + sample;
      ring[pos] = sample;
      pos++;
      if (pos >= len) pos = 0;
      next_slot = pos[3:0];
      owed_averages.push_back(SW'(window_sum / len));
    endfunction

    function void check_average(bit [SW-1:0] actual);
      bit [SW-1:0] wanted;
      if (owed_averages.size() == 0) begin
        $error("average: expected nothing, actual %0h", actual);
        failures++;
        return;
      end
      wanted = owed_averages.pop_front();
      if (actual !== wanted) begin
        $error("average: expected %0h, actual %0h", wanted, actual);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return owed_averages.size();
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [SW-1:0] in_sample = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [SW-1:0] out_average;
  logic          cfg_we = 1'b0;
  logic [LW-1:0] cfg_wdata = '0;

  // Set while neither side may idle.
  bit calm = 1'b0;

  AverageScoreboard sb = new;

  windowed_bandwidth_average uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_average(out_average),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: check each accepted average and stall at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_average(out_average);
    end
    out_stall <= !calm && ($urandom_range(0, 99) < 14);
  end

  // Offer one sample, with an occasional gap first, and hold it until accepted.
  task automatic send_sample(logic [SW-1:0] sample);
    if (!calm && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < 14) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= sample;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(sample);
  endtask

  // Stop offering requests and wait for every owed average to come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_length(logic [LW-1:0] value);
    wait_drained();
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    sb.set_window(value);
    cfg_we <= 1'b0;
  endtask

  // Samples lean towards the extremes and single-bit patterns.
  function automatic logic [SW-1:0] pick_sample();
    int unsigned roll;
    int unsigned bitpos;
    roll = $urandom_range(0, 15);
    bitpos = $urandom_range(0, SW - 1);
    case (roll)
      0, 1, 2, 3: return '1;
      4, 5:       return '0;
      6:          return SW'(1) << bitpos;
      7:          return ~(SW'(1) << bitpos);
      default:    return $urandom();
    endcase
  endfunction

  initial begin
    logic [SW-1:0] opening [10];
    bit [LW-1:0]   lengths [8];
    logic [SW-1:0] sample;
    opening = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 32'hAAAA_AAAA,
                32'h5555_5555, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF};
    lengths = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'd5, 5'd2};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset length of eight; the ring wraps within these requests.
    foreach (opening[i]) send_sample(opening[i]);

    // A zero length behaves as one.
    set_length(5'd0);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0);
    send_sample(32'hDEAD_BEEF);

    set_length(5'd1);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h3);

    // Oversized length saturates to the ring depth; nine maxima in a part-filled ring.
    set_length(5'd31);
    repeat (9) send_sample(32'hFFFF_FFFF);

    // Random part: one window length per phase, fixed ones first.
    for (int p = 0; p < PHASES; p++) begin
      if (p < 8) set_length(lengths[p]);
      else set_length(LW'($urandom_range(0, 31)));
      calm = (p == 2);
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        // Hold off once mid-phase until the block has emptied.
        if (p == 4 && i == 56) wait_drained();
        if (p == 0 && i < 20) sample = '1;
        else sample = pick_sample();
        send_sample(sample);
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("windowed_bandwidth_average verification clean");
    end else begin
      $display("windowed_bandwidth_average verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #1_000_000;
    $display("windowed_bandwidth_average verification failed");
    $finish;
  end

endmodule
